### design/scvc_pkg.sv
`timescale 1ns / 1ps
// Shared types and constants for the segment convex volume clip block.
// Used by the controller, the datapath and the top level.
package scvc_pkg;

  localparam int FracShift = 14;
  localparam int QuotBits  = 64;

  localparam logic ReqBegin = 1'b0;
  localparam logic ReqPlane = 1'b1;

  typedef struct packed {
    logic               req_type;
    logic signed [31:0] coord_a_x;
    logic signed [31:0] coord_a_y;
    logic signed [31:0] coord_a_z;
    logic signed [31:0] coord_b_x;
    logic signed [31:0] coord_b_y;
    logic signed [31:0] coord_b_z;
    logic signed [15:0] normal_x;
    logic signed [15:0] normal_y;
    logic signed [15:0] normal_z;
    logic signed [31:0] plane_offset;
    logic               last_plane;
  } in_word_t;

  typedef struct packed {
    logic               blocked;
    logic signed [31:0] span_start_x;
    logic signed [31:0] span_start_y;
    logic signed [31:0] span_start_z;
    logic signed [31:0] span_end_x;
    logic signed [31:0] span_end_y;
    logic signed [31:0] span_end_z;
  } out_word_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic       load_begin;  // copy endpoints, clear miss flag
    logic       load_plane;  // latch plane fields
    logic       mul_step;    // one product (axis 0..2 for endpoint sel)
    logic       mul_sel_end; // 0 start endpoint, 1 end endpoint
    logic [1:0] axis;        // axis for mul/div operations
    logic       dist_fin;    // finish distance of selected endpoint
    logic       classify;    // decide miss/straddle
    logic       div_start;   // start the divide for axis
    logic       div_step;    // one quotient bit
    logic       div_apply;   // update span for axis
    logic       emit;        // load output register
  } dp_cmd_t;

  typedef struct packed {
    logic missed;
    logic straddle;
    logic div_done;
  } dp_stat_t;

endpackage

### design/scvc_datapath.sv
`timescale 1ns / 1ps
// Datapath: span registers, a shared 32x16 multiplier, a 32x32 span multiplier and a restoring divider.
// Depends on scvc_pkg; driven by scvc_ctrl through dp_cmd_t.
module scvc_datapath (
  input  logic                 clk,
  input  logic                 rst,
  input  logic signed [21:0]   radius,
  input  scvc_pkg::in_word_t   in_word,
  input  scvc_pkg::dp_cmd_t    cmd,
  output scvc_pkg::dp_stat_t   stat,
  output scvc_pkg::out_word_t  out_word
);

  logic signed [31:0] span_start [3];
  logic signed [31:0] span_end   [3];
  logic               missed;
  logic signed [15:0] nrm [3];
  logic signed [31:0] offset;
  logic signed [63:0] acc;
  logic signed [47:0] prod;
  logic signed [31:0] d0u, d1u;
  logic               straddle;
  logic               move_start;
  logic signed [31:0] num;
  logic [31:0]        den;        // divisor magnitude
  logic               den_neg;
  logic [63:0]        dividend;   // magnitude, shifts left as quotient forms
  logic [63:0]        quot;
  logic [32:0]        rem;
  logic               neg_q;
  logic [6:0]         div_cnt;

  logic signed [31:0] mul_a;
  logic signed [63:0] acc_sum;
  logic signed [63:0] qf;
  logic signed [31:0] du;
  logic signed [31:0] d0, d1;
  logic [31:0]        a0, a1, den_w, den_s;
  logic signed [31:0] diff;
  logic signed [63:0] full;
  logic [32:0]        rem_sh, rem_sub;
  logic signed [31:0] step;

  always_comb begin
    mul_a = cmd.mul_sel_end ? span_end[cmd.axis] : span_start[cmd.axis];
    acc_sum = acc + 64'(prod);
    // floor division by 2^14 equals arithmetic shift
    qf = acc >>> scvc_pkg::FracShift;
    du = qf[31:0] + offset;
    d0 = d0u - 32'(radius);
    d1 = d1u - 32'(radius);
    a0 = d0u[31] ? -d0u : d0u;
    a1 = d1u[31] ? -d1u : d1u;
    den_w = a0 + a1;
    // The wrapped sum is a signed divisor; the divider works on magnitudes.
    den_s = (den_w == 0) ? 32'd1 : den_w;
    diff = span_end[cmd.axis] - span_start[cmd.axis];
    full = num * diff;
    rem_sh = {rem[31:0], dividend[63]};
    rem_sub = rem_sh - {1'b0, den};
    step = neg_q ? -quot[31:0] : quot[31:0];
  end

  always_ff @(posedge clk) begin
    prod <= mul_a * nrm[cmd.axis];
    if (rst) begin
      missed <= 1'b0;
      for (int i = 0; i < 3; i++) begin
        span_start[i] <= '0;
        span_end[i]   <= '0;
      end
      div_cnt <= '0;
    end else begin
      if (cmd.load_begin) begin
        span_start[0] <= in_word.coord_a_x;
        span_start[1] <= in_word.coord_a_y;
        span_start[2] <= in_word.coord_a_z;
        span_end[0]   <= in_word.coord_b_x;
        span_end[1]   <= in_word.coord_b_y;
        span_end[2]   <= in_word.coord_b_z;
        missed        <= 1'b0;
      end
      if (cmd.load_plane) begin
        nrm[0] <= in_word.normal_x;
        nrm[1] <= in_word.normal_y;
        nrm[2] <= in_word.normal_z;
        offset <= in_word.plane_offset;
        acc    <= '0;
      end
      if (cmd.mul_step) acc <= acc_sum;
      if (cmd.dist_fin) begin
        if (cmd.mul_sel_end) d1u <= du;
        else                 d0u <= du;
        acc <= '0;
      end
      if (cmd.classify) begin
        if (!d0[31] && d0 != 0 && !d1[31] && d1 != 0) missed <= 1'b1;
        straddle   <= (!d0[31] && d0 != 0) ^ (!d1[31] && d1 != 0);
        move_start <= !d0u[31];
        num        <= a0;
        den        <= den_s[31] ? -den_s : den_s;
        den_neg    <= den_s[31];
      end
      if (cmd.div_start) begin
        neg_q    <= full[63] ^ den_neg;
        dividend <= full[63] ? 64'(-full) : 64'(full);
        rem      <= '0;
        div_cnt  <= 7'(scvc_pkg::QuotBits);
      end
      if (cmd.div_step && div_cnt != 0) begin
        dividend <= {dividend[62:0], 1'b0};
        if (!rem_sub[32]) begin
          rem  <= rem_sub;
          quot <= {quot[62:0], 1'b1};
        end else begin
          rem  <= rem_sh;
          quot <= {quot[62:0], 1'b0};
        end
        div_cnt <= div_cnt - 7'd1;
      end
      if (cmd.div_apply) begin
        if (move_start) span_start[cmd.axis] <= span_start[cmd.axis] + step;
        else            span_end[cmd.axis]   <= span_start[cmd.axis] + step;
      end
      if (cmd.emit) begin
        out_word.blocked      <= !missed;
        out_word.span_start_x <= missed ? '0 : span_start[0];
        out_word.span_start_y <= missed ? '0 : span_start[1];
        out_word.span_start_z <= missed ? '0 : span_start[2];
        out_word.span_end_x   <= missed ? '0 : span_end[0];
        out_word.span_end_y   <= missed ? '0 : span_end[1];
        out_word.span_end_z   <= missed ? '0 : span_end[2];
      end
    end
  end

  assign stat.missed   = missed;
  assign stat.straddle = straddle;
  assign stat.div_done = (div_cnt == 0);

  mis_on_begin: assert property (@(posedge clk) disable iff (rst)
    cmd.load_begin |=> !missed)
    else $error("miss flag not cleared by begin word");
  div_counts: assert property (@(posedge clk) disable iff (rst)
    (cmd.div_step && div_cnt != 0) |=> div_cnt == $past(div_cnt) - 7'd1)
    else $error("divider count skipped");
  den_nonzero: assert property (@(posedge clk) disable iff (rst)
    $past(cmd.classify) |-> den != 0)
    else $error("zero divisor reached divider");

endmodule

### design/scvc_ctrl.sv
`timescale 1ns / 1ps
// Controller state machine sequencing one input word through the datapath.
// Depends on scvc_pkg; commands scvc_datapath and owns the handshakes.
module scvc_ctrl (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  input  logic               req_type,
  input  logic               last_plane,
  output logic               in_stall,
  output logic               out_valid,
  input  logic               out_stall,
  input  scvc_pkg::dp_stat_t stat,
  output scvc_pkg::dp_cmd_t  cmd
);

  typedef enum logic [2:0] {
    S_IDLE, S_MUL, S_CLASS, S_DIVLD, S_DIV, S_APPLY, S_DONE
  } state_t;

  state_t     state;
  logic       last;
  logic [2:0] mcnt;   // three products then finish, per endpoint
  logic       sel_end;
  logic [1:0] axis;
  logic       accept;

  assign in_stall = (state != S_IDLE) || (out_valid && out_stall);
  assign accept   = in_valid && !in_stall;

  always_comb begin
    cmd             = '0;
    cmd.axis        = axis;
    cmd.mul_sel_end = sel_end;
    cmd.load_begin  = accept && (req_type == scvc_pkg::ReqBegin);
    cmd.load_plane  = accept && (req_type == scvc_pkg::ReqPlane);
    unique case (state)
      S_MUL: begin
        // product of axis issued at mcnt 0..2, accumulated on the following cycle
        cmd.mul_step = (mcnt >= 3'd1) && (mcnt <= 3'd3);
        cmd.dist_fin = (mcnt == 3'd4);
        cmd.axis     = (mcnt < 3'd3) ? mcnt[1:0] : axis;
      end
      S_CLASS: cmd.classify  = 1'b1;
      S_DIVLD: cmd.div_start = 1'b1;
      S_DIV:   cmd.div_step  = 1'b1;
      S_APPLY: cmd.div_apply = 1'b1;
      S_DONE:  cmd.emit      = last;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
      last      <= 1'b0;
      mcnt      <= '0;
      sel_end   <= 1'b0;
      axis      <= '0;
    end else begin
      if (out_valid && !out_stall) out_valid <= 1'b0;
      unique case (state)
        S_IDLE: if (accept && req_type == scvc_pkg::ReqPlane) begin
          last    <= last_plane;
          mcnt    <= '0;
          sel_end <= 1'b0;
          state   <= stat.missed ? S_DONE : S_MUL;
        end
        S_MUL: begin
          if (mcnt == 3'd4) begin
            mcnt <= '0;
            if (sel_end) state <= S_CLASS;
            sel_end <= !sel_end;
          end else begin
            mcnt <= mcnt + 3'd1;
          end
        end
        S_CLASS: begin
          axis  <= '0;
          state <= S_DIVLD;
        end
        S_DIVLD: state <= stat.straddle ? S_DIV : S_DONE;
        S_DIV:   if (stat.div_done) state <= S_APPLY;
        S_APPLY: begin
          if (axis == 2'd2) begin
            state <= S_DONE;
          end else begin
            axis  <= axis + 2'd1;
            state <= S_DIVLD;
          end
        end
        S_DONE: begin
          if (last) out_valid <= 1'b1;
          state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  busy_blocks: assert property (@(posedge clk) disable iff (rst)
    (state != S_IDLE) |-> in_stall)
    else $error("word accepted while busy");
  emit_last: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(state == S_DONE && last))
    else $error("result without last plane");
  div_exit: assert property (@(posedge clk) disable iff (rst)
    (state == S_APPLY) |-> $past(state == S_DIV))
    else $error("span update without finished divide");

endmodule

### design/segment_convex_volume_clip_core.sv
`timescale 1ns / 1ps
// Top level of the segment convex volume clip block.
// Depends on scvc_pkg, scvc_ctrl and scvc_datapath.
//
// Usage: words enter on in_word with in_valid/in_stall and results leave on
// out_word with out_valid/out_stall; a word moves on a clock edge with valid
// high and stall low. A begin word loads the segment. A plane word runs the
// distance and classify steps, and on a straddle the shared restoring
// divider produces one quotient bit per cycle over 64 bits for each of the
// three axes. After a miss further planes go straight to the done state.
// For a plane word with last_plane set, out_valid rises from the done state.
// The input is stalled while a word is being worked on and while an
// unaccepted result is held, so a receiver stall only holds the result
// register steady. Synchronous reset clears the span to zero, the miss flag
// and the radius register; there is no clearing pass. The radius is written
// through cfg_we/cfg_data; the user must write it only while idle, and the
// block itself does not enforce this.
module segment_convex_volume_clip_core (
  input  logic                clk,
  input  logic                rst,
  input  logic                cfg_we,
  input  logic signed [21:0]  cfg_data,
  input  logic                in_valid,
  output logic                in_stall,
  input  scvc_pkg::in_word_t  in_word,
  output logic                out_valid,
  input  logic                out_stall,
  output scvc_pkg::out_word_t out_word
);

  logic signed [21:0] radius;
  scvc_pkg::dp_cmd_t  cmd;
  scvc_pkg::dp_stat_t stat;

  always_ff @(posedge clk) begin
    if (rst) radius <= '0;
    else if (cfg_we) radius <= cfg_data;
  end

  scvc_ctrl u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .req_type   (in_word.req_type),
    .last_plane (in_word.last_plane),
    .in_stall   (in_stall),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .stat       (stat),
    .cmd        (cmd)
  );

  scvc_datapath u_dp (
    .clk      (clk),
    .rst      (rst),
    .radius   (radius),
    .in_word  (in_word),
    .cmd      (cmd),
    .stat     (stat),
    .out_word (out_word)
  );

endmodule
